>>> rtl/awu_pkg.sv
// ----------------------------------------------------------------------------
// awu_pkg
// Shared types and constants of the Adam weight update unit.
// ----------------------------------------------------------------------------
package awu_pkg;

	localparam int ENTRIES = 4096;
	localparam int AW      = $clog2(ENTRIES);
	localparam int DW      = 64;
	localparam int VW      = 49;

	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

	localparam int CFG_IW = 3;
	localparam logic [CFG_IW-1:0] CFG_LR  = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_B1  = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_B2  = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_EPS = 3'd3;

	typedef struct packed {
		logic [11:0]        entry_index;
		logic signed [31:0] gradient;
		logic signed [31:0] current_weight;
		logic               pass_start;
	} awu_in_t;

	typedef struct packed {
		logic signed [31:0] updated_weight;
		logic [11:0]        echo_index;
	} awu_out_t;

	typedef struct packed {
		logic start;
	} awu_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} awu_sts_t;

endpackage

>>> rtl/adam_weight_update_unit.sv
// ----------------------------------------------------------------------------
// adam_weight_update_unit
// Adam optimizer step with moment memories and bias correction.
// ----------------------------------------------------------------------------
// An item passes through memory read and moment update, up to three runs of one
// shared divider, a square root and control states. One item is worked at a
// time and the next transfer can be taken in the cycle after the result is
// loaded. After reset a clearing pass zeroes both moment memories;
// configuration is at once.
// ----------------------------------------------------------------------------
module adam_weight_update_unit import awu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wen,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [23:0]       cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  awu_in_t           in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output awu_out_t          out_data
);

	typedef enum logic [15:0] {
		S_CLEAR = 16'b0000_0000_0000_0001,
		S_IDLE  = 16'b0000_0000_0000_0010,
		S_RD    = 16'b0000_0000_0000_0100,
		S_M1    = 16'b0000_0000_0000_1000,
		S_M2    = 16'b0000_0000_0001_0000,
		S_V1    = 16'b0000_0000_0010_0000,
		S_V2    = 16'b0000_0000_0100_0000,
		S_V3    = 16'b0000_0000_1000_0000,
		S_DM    = 16'b0000_0001_0000_0000,
		S_VH    = 16'b0000_0010_0000_0000,
		S_DV    = 16'b0000_0100_0000_0000,
		S_SQS   = 16'b0000_1000_0000_0000,
		S_SQ    = 16'b0001_0000_0000_0000,
		S_DSS   = 16'b0010_0000_0000_0000,
		S_DS    = 16'b0100_0000_0000_0000,
		S_FIN   = 16'b1000_0000_0000_0000
	} state_t;

	state_t state_q;

	logic [23:0] lr_q;
	logic [15:0] b1_q;
	logic [15:0] b2_q;
	logic [15:0] eps_q;
	logic [32:0] p1_q;
	logic [32:0] p2_q;

	logic [AW-1:0] clr_q;
	logic [AW-1:0] idx_q;
	awu_in_t       item_q;

	logic signed [48:0] pa_q;
	logic signed [48:0] pb_q;
	logic [47:0]        pc_q;
	logic [48:0]        pd_q;
	logic [31:0]        v_q;
	logic [31:0]        gsq_q;
	logic signed [31:0] mnew_q;
	logic [31:0]        vnew_q;
	logic               neg_q;
	logic [31:0]        mhat_q;
	logic [47:0]        vhat_q;
	logic [VW-1:0]      den_q;
	logic [55:0]        prod_q;
	logic [32:0]        step_q;

	logic          div_go_q;
	logic [DW-1:0] div_num_q;
	logic [VW-1:0] div_den_q;
	logic          sq_go_q;
	logic [63:0]   sq_in_q;
	awu_sts_t      div_sts;
	awu_sts_t      sq_sts;
	logic [DW-1:0] div_q;
	logic [31:0]   sq_root;

	logic          out_valid_q;
	awu_out_t      out_q;

	logic [48:0]        p1_prod;
	logic [48:0]        p2_prod;
	logic [32:0]        d1;
	logic [32:0]        d2;
	logic [16:0]        c1;
	logic [16:0]        c2;
	logic [31:0]        gmag;
	logic [63:0]        gsq_full;
	logic signed [49:0] msum;
	logic signed [31:0] mnew;
	logic [49:0]        vsum;
	logic [31:0]        vnew;
	logic [31:0]        mmag;
	logic [VW-1:0]      den;
	logic signed [34:0] res;
	logic signed [31:0] res_sat;

	logic          m_we;
	logic          v_we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [31:0]   m_wdata;
	logic [31:0]   v_wdata;
	logic [31:0]   m_rd;
	logic [31:0]   v_rd;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign p1_prod  = p1_q * b1_q;
	assign p2_prod  = p2_q * b2_q;
	assign d1       = ONE_Q32 - p1_q;
	assign d2       = ONE_Q32 - p2_q;
	assign c1       = 17'h1_0000 - {1'b0, b1_q};
	assign c2       = 17'h1_0000 - {1'b0, b2_q};
	assign gmag     = item_q.gradient[31] ? 32'(-item_q.gradient) : item_q.gradient;
	assign gsq_full = gmag * gmag;
	assign msum     = 50'(pa_q) + 50'(pb_q);
	assign mnew     = 32'(msum >>> 16);
	assign vsum     = 50'(pc_q) + 50'(pd_q);
	assign vnew     = vsum[47:16];
	assign mmag     = mnew_q[31] ? 32'(-mnew_q) : mnew_q;
	assign den      = {1'b0, sq_root, 16'b0} + VW'(eps_q);
	assign res      = neg_q ? 35'(item_q.current_weight) + $signed({2'b0, step_q})
	                        : 35'(item_q.current_weight) - $signed({2'b0, step_q});

	always_comb begin
		if (res > 35'sh0_7FFF_FFFF) begin
			res_sat = 32'sh7FFF_FFFF;
		end else if (res < $signed(35'h7_8000_0000)) begin
			res_sat = $signed(32'h8000_0000);
		end else begin
			res_sat = res[31:0];
		end
	end

	assign raddr   = AW'(in_data.entry_index % ENTRIES);
	assign waddr   = (state_q == S_CLEAR) ? clr_q : idx_q;
	assign m_we    = (state_q == S_CLEAR) || (state_q == S_M2);
	assign v_we    = (state_q == S_CLEAR) || (state_q == S_V3);
	assign m_wdata = (state_q == S_CLEAR) ? 32'b0 : mnew;
	assign v_wdata = (state_q == S_CLEAR) ? 32'b0 : vnew;

	awu_ram #(.W(32), .DEPTH(ENTRIES)) u_m_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (waddr),
		.wdata (m_wdata),
		.raddr (raddr),
		.rdata (m_rd)
	);

	awu_ram #(.W(32), .DEPTH(ENTRIES)) u_v_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (waddr),
		.wdata (v_wdata),
		.raddr (raddr),
		.rdata (v_rd)
	);

	awu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      ('{start: div_go_q}),
		.dividend (div_num_q),
		.divisor  (div_den_q),
		.sts      (div_sts),
		.quotient (div_q)
	);

	awu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      ('{start: sq_go_q}),
		.radicand (sq_in_q),
		.sts      (sq_sts),
		.root     (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q  <= 24'd16777;
			b1_q  <= 16'd58982;
			b2_q  <= 16'd65470;
			eps_q <= 16'd1;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_LR:  lr_q  <= cfg_data;
				CFG_B1:  b1_q  <= cfg_data[15:0];
				CFG_B2:  b2_q  <= cfg_data[15:0];
				CFG_EPS: eps_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			p1_q        <= ONE_Q32;
			p2_q        <= ONE_Q32;
			div_go_q    <= 1'b0;
			sq_go_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			sq_go_q  <= 1'b0;
			if (out_valid_q && out_ready && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(ENTRIES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						if (in_data.pass_start) begin
							p1_q <= 33'(p1_prod >> 16);
							p2_q <= 33'(p2_prod >> 16);
						end
						state_q <= S_RD;
					end
				end
				S_RD:  state_q <= S_M1;
				S_M1:  state_q <= S_M2;
				S_M2:  state_q <= S_V1;
				S_V1:  state_q <= S_V2;
				S_V2:  state_q <= S_V3;
				S_V3: begin
					if (d1 == 33'b0) begin
						state_q <= S_VH;
					end else begin
						div_go_q <= 1'b1;
						state_q  <= S_DM;
					end
				end
				S_DM: begin
					if (div_sts.done) begin
						state_q <= S_VH;
					end
				end
				S_VH: begin
					if (d2 == 33'b0) begin
						state_q <= S_SQS;
					end else begin
						div_go_q <= 1'b1;
						state_q  <= S_DV;
					end
				end
				S_DV: begin
					if (div_sts.done) begin
						state_q <= S_SQS;
					end
				end
				S_SQS: begin
					sq_go_q <= 1'b1;
					state_q <= S_SQ;
				end
				S_SQ: begin
					if (sq_sts.done) begin
						state_q <= S_DSS;
					end
				end
				S_DSS: begin
					div_go_q <= 1'b1;
					state_q  <= S_DS;
				end
				S_DS: begin
					if (div_sts.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				item_q <= in_data;
				idx_q  <= raddr;
			end
			S_RD: begin
				pa_q <= 49'($signed({1'b0, b1_q}) * $signed(m_rd));
				v_q  <= v_rd;
			end
			S_M1: begin
				pb_q <= 49'($signed({1'b0, c1}) * item_q.gradient);
			end
			S_M2: begin
				mnew_q <= mnew;
				gsq_q  <= gsq_full[63:32];
			end
			S_V1: begin
				pc_q <= b2_q * v_q;
			end
			S_V2: begin
				pd_q <= c2 * gsq_q;
			end
			S_V3: begin
				vnew_q    <= vnew;
				neg_q     <= mnew_q[31];
				mhat_q    <= mmag;
				div_num_q <= {mmag, 32'b0};
				div_den_q <= VW'(d1);
			end
			S_DM: begin
				if (div_sts.done) begin
					mhat_q <= (div_q > 64'h8000_0000) ? 32'h8000_0000 : div_q[31:0];
				end
			end
			S_VH: begin
				vhat_q    <= 48'(vnew_q);
				div_num_q <= {vnew_q, 32'b0};
				div_den_q <= VW'(d2);
			end
			S_DV: begin
				if (div_sts.done) begin
					vhat_q <= (div_q > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF
					                                       : div_q[47:0];
				end
			end
			S_SQS: begin
				sq_in_q <= {vhat_q, 16'b0};
			end
			S_SQ: begin
				den_q  <= (den == '0) ? VW'(1) : den;
				prod_q <= lr_q * mhat_q;
			end
			S_DSS: begin
				div_num_q <= {prod_q, 8'b0};
				div_den_q <= den_q;
			end
			S_DS: begin
				if (div_sts.done) begin
					step_q <= (div_q > 64'h1_0000_0000) ? ONE_Q32 : div_q[32:0];
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_q.updated_weight <= res_sat;
					out_q.echo_index     <= item_q.entry_index;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transfer taken while an item is in progress");
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !in_ready)
		else $error("transfer taken during the clearing pass");
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_go_q |-> !div_sts.busy)
		else $error("divider started while busy");
	a_sqrt_free: assert property (@(posedge clk) disable iff (!arst_n)
		sq_go_q |-> !sq_sts.busy && !div_sts.busy)
		else $error("square root started while a unit is busy");
`endif

endmodule

>>> rtl/awu_ram.sv
// ----------------------------------------------------------------------------
// awu_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module awu_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/awu_div.sv
// ----------------------------------------------------------------------------
// awu_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module awu_div import awu_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  awu_ctl_t      ctl,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output awu_sts_t      sts,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] num_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dsr_q;
	logic [VW:0]   rem_sh;
	logic          ge;
	logic [VW:0]   rem_nx;

	assign rem_sh = {rem_q, num_q[DW-1]};
	assign ge     = rem_sh >= {1'b0, dsr_q};
	assign rem_nx = ge ? rem_sh - {1'b0, dsr_q} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			num_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DW-2:0], ge};
			rem_q <= rem_nx[VW-1:0];
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = num_q;

endmodule

>>> rtl/awu_sqrt.sv
// ----------------------------------------------------------------------------
// awu_sqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module awu_sqrt import awu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  awu_ctl_t    ctl,
	input  logic [63:0] radicand,
	output awu_sts_t    sts,
	output logic [31:0] root
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] x_q;
	logic [63:0] r_q;
	logic [63:0] bit_q;
	logic [63:0] sum;
	logic        take;

	assign sum  = r_q + bit_q;
	assign take = x_q >= sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q   <= radicand;
			r_q   <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (take) begin
				x_q <= x_q - sum;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign root     = r_q[31:0];

endmodule

>>> tb/sv/adam_weight_update_unit_test.sv
// ----------------------------------------------------------------------------
// adam_weight_update_unit_test
// Self-checking bench for the Adam weight update unit. A directed table covers
// field extremes and pass starts, directed register settings cover zero epsilon,
// then random transfers follow. The bench keeps its own model of the moment
// memories, the beta powers and the registers, predicts every result and
// compares it with the output stream. Random idle gaps are placed on both sides,
// and the run also includes a long output stall and a full drain.
// ----------------------------------------------------------------------------
module adam_weight_update_unit_test;
	import awu_pkg::*;

	localparam logic [CFG_IW-1:0] CFG_NONE = 3'd7;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wen = 1'b0;
	logic [CFG_IW-1:0] cfg_index = CFG_LR;
	logic [23:0]       cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	awu_in_t           in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	awu_out_t          out_data;

	adam_weight_update_unit DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct {
		awu_in_t  stim;
		logic     has_fixed;
		awu_out_t fixed;
	} row_t;

	logic signed [31:0] mom1 [ENTRIES];
	logic [31:0]        mom2 [ENTRIES];
	logic [32:0]        pow1, pow2;
	logic [23:0]        lr;
	logic [15:0]        b1, b2, eps;
	awu_out_t           pending [$];
	int                 fails = 0;
	bit                 stall_long = 0;

	function automatic logic [63:0] isqrt(input logic [63:0] x);
		logic [63:0] r, bt;
		r = 0;
		bt = 64'd1 << 62;
		while (bt > x) bt >>= 2;
		while (bt != 0) begin
			if (x >= r + bt) begin
				x = x - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r >>= 1;
			end
			bt >>= 2;
		end
		return r;
	endfunction

	function automatic awu_out_t adam_step(input awu_in_t s);
		logic [11:0] k;
		longint g, w, mn, acc, res;
		logic [63:0] gm, gsq, vn, d1, d2, mm, mh, vh, rt, den;
		logic [127:0] num;
		logic [127:0] st;
		bit neg;
		awu_out_t o;
		k = 12'(s.entry_index % ENTRIES);
		g = longint'(s.gradient);
		w = longint'(s.current_weight);
		if (s.pass_start) begin
			pow1 = 33'((64'(pow1) * b1) >> 16);
			pow2 = 33'((64'(pow2) * b2) >> 16);
		end
		acc = longint'(b1) * longint'(mom1[k]) + (65536 - longint'(b1)) * g;
		mn = acc >>> 16;
		mom1[k] = mn[31:0];
		gm = (g < 0) ? 64'(-g) : 64'(g);
		gsq = (gm * gm) >> 32;
		vn = (64'(b2) * mom2[k] + (64'd65536 - b2) * gsq) >> 16;
		mom2[k] = vn[31:0];
		d1 = 64'(ONE_Q32) - pow1;
		d2 = 64'(ONE_Q32) - pow2;
		neg = mn < 0;
		mm = neg ? 64'(-mn) : 64'(mn);
		mh = (d1 == 0) ? mm : (mm << 32) / d1;
		if (mh > (64'd1 << 31)) mh = 64'd1 << 31;
		vh = (d2 == 0) ? vn : (vn << 32) / d2;
		if (vh > ((64'd1 << 48) - 1)) vh = (64'd1 << 48) - 1;
		rt = isqrt(vh << 16);
		den = (rt << 16) + eps;
		if (den == 0) den = 1;
		num = (128'(lr) * mh) << 8;
		st = num / den;
		if (st > 128'(ONE_Q32)) st = 128'(ONE_Q32);
		res = neg ? w + longint'(st) : w - longint'(st);
		if (res > 64'sd2147483647) res = 64'sd2147483647;
		if (res < -64'sd2147483648) res = -64'sd2147483648;
		o.updated_weight = res[31:0];
		o.echo_index = s.entry_index;
		return o;
	endfunction

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [23:0] val);
		@(negedge clk);
		cfg_wen = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_wen = 1'b0;
		case (idx)
			CFG_LR:  lr = val;
			CFG_B1:  b1 = val[15:0];
			CFG_B2:  b2 = val[15:0];
			CFG_EPS: eps = val[15:0];
			default: ;
		endcase
	endtask

	task automatic gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) n = 0;
		repeat (n) @(negedge clk);
	endtask

	task automatic send(input awu_in_t s, input bit fixed_ok, input awu_out_t fixed);
		awu_out_t p;
		@(negedge clk);
		in_data = s;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		p = adam_step(s);
		if (fixed_ok && p !== fixed) begin
			$error("table row disagrees with prediction: exp %h got %h", fixed, p);
			fails++;
		end
		pending.push_back(p);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic drain();
		while (pending.size() != 0) @(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	function automatic awu_in_t rand_item(input bit start_ok);
		awu_in_t s;
		s.entry_index = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 15));
		case ($urandom_range(0, 3))
			0: s.gradient = $urandom;
			1: s.gradient = 32'($signed(12'($urandom))) <<< $urandom_range(0, 20);
			2: s.gradient = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: s.gradient = 32'($signed(24'($urandom)));
		endcase
		s.current_weight = ($urandom_range(0, 5) == 0) ?
			($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000) : $urandom;
		s.pass_start = start_ok && ($urandom_range(0, 15) == 0);
		return s;
	endfunction

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pending.size() == 0) begin
				$error("result with nothing expected: %h", out_data);
				fails++;
			end else begin
				if (out_data.updated_weight !== pending[0].updated_weight) begin
					$error("updated_weight exp %h got %h",
						pending[0].updated_weight, out_data.updated_weight);
					fails++;
				end
				if (out_data.echo_index !== pending[0].echo_index) begin
					$error("echo_index exp %h got %h",
						pending[0].echo_index, out_data.echo_index);
					fails++;
				end
				void'(pending.pop_front());
			end
		end
	end

	initial begin
		int n;
		@(negedge clk);
		forever begin
			if (stall_long) begin
				out_ready <= 1'b0;
				repeat (2000) @(negedge clk);
				stall_long = 0;
			end
			n = $urandom_range(0, 9);
			out_ready <= (n > 2) || ($urandom_range(0, 5) == 0);
			if (n == 0) begin
				repeat ($urandom_range(20, 300)) @(negedge clk);
			end else begin
				@(negedge clk);
			end
		end
	end

	initial begin
		#200_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		row_t tbl [$];
		row_t r;
		int n;
		awu_out_t nul;
		for (int i = 0; i < ENTRIES; i++) begin
			mom1[i] = 0;
			mom2[i] = 0;
		end
		pow1 = ONE_Q32;
		pow2 = ONE_Q32;
		lr = 24'd16777;
		b1 = 16'd58982;
		b2 = 16'd65470;
		eps = 16'd1;
		nul = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Zero gradient leaves the weight untouched before any pass start.
		r.has_fixed = 1; r.stim = '{12'd0, 32'sd0, 32'sh7fffffff, 1'b0};
		r.fixed = '{32'sh7fffffff, 12'd0}; tbl.push_back(r);
		r.stim = '{12'hfff, 32'sd0, 32'sh80000000, 1'b0};
		r.fixed = '{32'sh80000000, 12'hfff}; tbl.push_back(r);
		r.has_fixed = 0;
		r.stim = '{12'd1, 32'sh7fffffff, 32'sh80000000, 1'b0}; tbl.push_back(r);
		r.stim = '{12'd2, 32'sh80000000, 32'sh7fffffff, 1'b0}; tbl.push_back(r);
		r.stim = '{12'd1, 32'sh7fffffff, 32'sd0, 1'b1}; tbl.push_back(r);
		r.stim = '{12'd2, 32'sh80000000, 32'sd0, 1'b0}; tbl.push_back(r);
		r.stim = '{12'd3, 32'sd1, 32'sd0, 1'b1}; tbl.push_back(r);
		r.stim = '{12'd3, -32'sd1, 32'sd5, 1'b0}; tbl.push_back(r);
		r.stim = '{12'h800, 32'sh01000000, 32'sh00800000, 1'b1}; tbl.push_back(r);
		r.stim = '{12'h7ff, -32'sh01000000, -32'sh00800000, 1'b0}; tbl.push_back(r);
		foreach (tbl[i]) begin
			gap();
			send(tbl[i].stim, tbl[i].has_fixed, tbl[i].fixed);
		end
		drain();

		// Extreme settings: zero epsilon with a fresh entry hits the zero divisor case.
		write_reg(CFG_EPS, 24'd0);
		write_reg(CFG_LR, 24'hffffff);
		write_reg(CFG_B1, 24'd0);
		write_reg(CFG_B2, 24'd0);
		write_reg(CFG_NONE, 24'h123456);
		send('{12'd100, 32'sd0, 32'sd7, 1'b0}, 1, '{32'sd7, 12'd100});
		send('{12'd101, 32'sh00000100, 32'sd0, 1'b1}, 0, nul);
		send('{12'd102, -32'sh40000000, 32'sh7fff0000, 1'b0}, 0, nul);
		drain();
		write_reg(CFG_B1, 24'hffff);
		write_reg(CFG_B2, 24'hffff);
		write_reg(CFG_EPS, 24'hffff);
		write_reg(CFG_LR, 24'd0);
		send('{12'd5, 32'sh7fffffff, 32'sd9, 1'b1}, 1, '{32'sd9, 12'd5});
		drain();
		write_reg(CFG_LR, 24'd16777);
		write_reg(CFG_B1, 24'd58982);
		write_reg(CFG_B2, 24'd65470);
		write_reg(CFG_EPS, 24'd1);

		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 1) begin
				stall_long = 1;
				for (int i = 0; i < 6; i++) send(rand_item(1), 0, nul);
			end
			n = 220;
			for (int i = 0; i < n; i++) begin
				gap();
				send(rand_item(1), 0, nul);
			end
			drain();
			write_reg(CFG_LR, 24'($urandom));
			write_reg(CFG_B1, 24'($urandom_range(30000, 65535)));
			write_reg(CFG_B2, 24'($urandom_range(50000, 65535)));
			write_reg(CFG_EPS, 24'($urandom_range(0, 3) == 0 ? 0 : $urandom));
		end
		drain();
		if (fails == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
